// ----- sv/prir_pkg.sv -----
// Shared types, constants and decode functions for the PC-relative instruction relocator.
`default_nettype none

package prir_pkg;

  // Field widths of the data channels.
  localparam int WORD_W    = 32;
  localparam int ADDR_W    = 64;
  localparam int POS_W     = 11;
  localparam int CAUSE_W   = 2;
  localparam int MAX_WORDS = 5;
  localparam int SLOT_W    = 3;

  // Opcode masks and match values.
  localparam logic [WORD_W-1:0] ADR_MASK   = 32'h9F00_0000;
  localparam logic [WORD_W-1:0] ADRP_MATCH = 32'h9000_0000;
  localparam logic [WORD_W-1:0] ADR_MATCH  = 32'h1000_0000;
  localparam logic [WORD_W-1:0] BR_MASK    = 32'hFC00_0000;
  localparam logic [WORD_W-1:0] B_MATCH    = 32'h1400_0000;
  localparam logic [WORD_W-1:0] BL_MATCH   = 32'h9400_0000;
  localparam logic [WORD_W-1:0] RET_WORD   = 32'hD65F_03C0;

  // Words placed in the rewritten sequences.
  localparam logic [WORD_W-1:0] LDR_LIT    = 32'h5800_0000;
  localparam logic [WORD_W-1:0] BR_X16     = 32'hD61F_0200;
  localparam logic [WORD_W-1:0] BLR_X16    = 32'hD63F_0200;
  localparam logic [WORD_W-1:0] SKIP_B12   = 32'h1400_0003;
  localparam logic [4:0]        REG_X16    = 5'd16;
  localparam logic [18:0]       LDR_SKIP8  = 19'd2;
  localparam logic [18:0]       LDR_SKIP12 = 19'd3;

  // End causes reported on the last word of a source instruction.
  localparam logic [CAUSE_W-1:0] CAUSE_NONE  = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_B     = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_RET   = 2'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_LIMIT = 2'd3;

  typedef enum logic [2:0] {
    KIND_ADRP,
    KIND_ADR,
    KIND_B,
    KIND_BL,
    KIND_OTHER
  } kind_t;

  // One taken source instruction with its program counter and output position.
  typedef struct packed {
    logic                valid;
    logic [WORD_W-1:0]   word;
    logic [ADDR_W-1:0]   pc;
    logic [POS_W-1:0]    pos;
    logic [CAUSE_W-1:0]  cause;
  } stage_t;

  // Classify a source instruction word.
  function automatic kind_t decode_kind(input logic [WORD_W-1:0] w);
    kind_t k;
    if ((w & ADR_MASK) == ADRP_MATCH) begin
      k = KIND_ADRP;
    end else if ((w & ADR_MASK) == ADR_MATCH) begin
      k = KIND_ADR;
    end else if ((w & BR_MASK) == B_MATCH) begin
      k = KIND_B;
    end else if ((w & BR_MASK) == BL_MATCH) begin
      k = KIND_BL;
    end else begin
      k = KIND_OTHER;
    end
    return k;
  endfunction

  // Number of output words a source instruction expands to.
  function automatic logic [SLOT_W-1:0] word_count(input kind_t k);
    logic [SLOT_W-1:0] n;
    case (k)
      KIND_ADRP: n = 3'd4;
      KIND_ADR:  n = 3'd4;
      KIND_B:    n = 3'd4;
      KIND_BL:   n = 3'd5;
      default:   n = 3'd1;
    endcase
    return n;
  endfunction

  // LDR (literal) of a 64-bit register from a word offset ahead of the PC.
  function automatic logic [WORD_W-1:0] ldr_literal(input logic [4:0] rt,
                                                    input logic [18:0] imm19);
    return LDR_LIT | {8'h00, imm19, rt};
  endfunction

endpackage

`default_nettype wire

// ----- sv/prir_in_if.sv -----
// Input channel carrying source instruction words.
`default_nettype none

interface prir_in_if import prir_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] instr_word;
  logic              first_of_function;

  modport source (output valid, output instr_word, output first_of_function, input ready);
  modport sink (input valid, input instr_word, input first_of_function, output ready);
endinterface

`default_nettype wire

// ----- sv/prir_out_if.sv -----
// Output channel carrying relocated words with their positions.
`default_nettype none

interface prir_out_if import prir_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  out_word;
  logic [POS_W-1:0]   out_position;
  logic               first_of_run;
  logic               last_of_run;
  logic [CAUSE_W-1:0] end_cause;

  modport source (output valid, output out_word, output out_position, output first_of_run,
                  output last_of_run, output end_cause, input ready);
  modport sink (input valid, input out_word, input out_position, input first_of_run,
                input last_of_run, input end_cause, output ready);
endinterface

`default_nettype wire

// ----- sv/pc_relative_instruction_relocator.sv -----
// Top level of the relocator: configuration registers, the two stages and checks.
// Throughput: one input item per cycle while items pass unchanged and the output
// is not stalled; ADR, ADRP and B expand to four words and BL to five, as the
// output register sends one word per cycle unless stalled.
// Reset: counters clear, the block waits for a first-of-function item, base_address
// reads 0 and max_instructions reads 256.
`default_nettype none

module pc_relative_instruction_relocator import prir_pkg::*; #(
  parameter int MAX_SOURCE = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  prir_in_if.sink          instr,
  prir_out_if.source       result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready
);

  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  logic [ADDR_W-1:0] base_address;
  logic [8:0]        max_instructions;
  logic              cfg_write;
  stage_t            stage;
  logic              stage_take;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers, one 64-bit slot each.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address     <= '0;
      max_instructions <= 9'd256;
    end else if (cfg_write) begin
      case (paddr[3])
        REG_BASE:  base_address     <= pwdata;
        REG_LIMIT: max_instructions <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3])
      REG_BASE:  prdata = base_address;
      REG_LIMIT: prdata = {55'd0, max_instructions};
      default:   prdata = '0;
    endcase
  end

  prir_front #(
    .MAX_SOURCE (MAX_SOURCE)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .instr            (instr),
    .base_address     (base_address),
    .max_instructions (max_instructions),
    .stage_take       (stage_take),
    .stage            (stage)
  );

  prir_expand u_expand (
    .clk        (clk),
    .rst        (rst),
    .stage      (stage),
    .stage_take (stage_take),
    .result     (result)
  );

`ifndef SYNTHESIS
  // A word that is not the last of its run is followed at once by the next word.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && !result.last_of_run |=>
      result.valid && !result.first_of_run)
    else $error("run of words was broken");

  // Positions inside one run advance by one word.
  a_position_step: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && !result.last_of_run |=>
      result.out_position == $past(result.out_position) + POS_W'(1))
    else $error("output position did not advance by one");

  // The input is held off only while the stage register carries an item.
  a_ready_busy: assert property (@(posedge clk) disable iff (rst)
    !instr.ready |-> stage.valid)
    else $error("input stalled with an empty stage");
`endif

endmodule

`default_nettype wire

// ----- sv/prir_front.sv -----
// Input stage: function tracking, limit check and program counter formation.
`default_nettype none

module prir_front import prir_pkg::*; #(
  parameter int MAX_SOURCE = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  prir_in_if.sink                instr,
  input  wire logic [ADDR_W-1:0] base_address,
  input  wire logic [8:0]        max_instructions,
  input  wire logic              stage_take,
  output stage_t                 stage
);

  localparam int IDXW = $clog2(MAX_SOURCE + 1);
  localparam int CW   = ((IDXW > 9) ? IDXW : 9) + 1;

  logic [IDXW-1:0]    source_index;
  logic [IDXW-1:0]    source_index_next;
  logic [POS_W-1:0]   output_count;
  logic [POS_W-1:0]   output_count_next;
  logic               function_done;
  logic               function_done_next;
  stage_t             stage_next;

  logic [CW-1:0]      limit_req;
  logic [CW-1:0]      limit;
  logic               accept;
  logic               first;
  logic [IDXW-1:0]    idx_start;
  logic [POS_W-1:0]   cnt_start;
  logic               done_start;
  logic [IDXW-1:0]    idx_inc;
  logic               limit_hit;
  kind_t              kind;
  logic [CAUSE_W-1:0] cause_br;
  logic [CAUSE_W-1:0] cause;
  logic [ADDR_W-1:0]  pc;

  // Outside reset, the stage register takes a new item when empty or when it hands its
  // item on.
  assign instr.ready = !rst && (!stage.valid || stage_take);
  assign accept      = instr.valid && instr.ready;
  assign first       = instr.first_of_function;

  // Effective limit is the configured count clamped to the table size.
  always_comb begin
    limit_req = {{(CW-9){1'b0}}, max_instructions};
    limit     = (limit_req > CW'(MAX_SOURCE)) ? CW'(MAX_SOURCE) : limit_req;
  end

  // A first-of-function item restarts the counters before it is judged.
  always_comb begin
    idx_start  = first ? '0 : source_index;
    cnt_start  = first ? '0 : output_count;
    done_start = first ? (limit == '0) : function_done;
    idx_inc    = idx_start + IDXW'(1);
    limit_hit  = ({{(CW-IDXW){1'b0}}, idx_inc} >= limit);
    kind       = decode_kind(instr.instr_word);
    pc         = base_address + {{(ADDR_W-2-IDXW){1'b0}}, idx_start, 2'b00};
  end

  // A B branch (not BL) or a return ends the function ahead of the limit.
  always_comb begin
    case (kind)
      KIND_B:  cause_br = CAUSE_B;
      default: cause_br = (instr.instr_word == RET_WORD) ? CAUSE_RET : CAUSE_NONE;
    endcase
    if (cause_br != CAUSE_NONE) begin
      cause = cause_br;
    end else if (limit_hit) begin
      cause = CAUSE_LIMIT;
    end else begin
      cause = CAUSE_NONE;
    end
  end

  // Next state of the function tracking and the stage register.
  always_comb begin
    source_index_next  = source_index;
    output_count_next  = output_count;
    function_done_next = function_done;
    stage_next         = stage;
    if (accept) begin
      if (done_start) begin
        source_index_next  = idx_start;
        output_count_next  = cnt_start;
        function_done_next = 1'b1;
      end else begin
        source_index_next  = idx_inc;
        output_count_next  = cnt_start + {{(POS_W-SLOT_W){1'b0}}, word_count(kind)};
        function_done_next = (cause != CAUSE_NONE);
      end
    end
    if (instr.ready) begin
      stage_next.valid = accept && !done_start;
      stage_next.word  = instr.instr_word;
      stage_next.pc    = pc;
      stage_next.pos   = cnt_start;
      stage_next.cause = cause;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_index  <= '0;
      output_count  <= '0;
      function_done <= 1'b1;
      stage.valid   <= 1'b0;
    end else begin
      source_index  <= source_index_next;
      output_count  <= output_count_next;
      function_done <= function_done_next;
      stage         <= stage_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/prir_expand.sv -----
// Rewrite stage: target address, expanded word record and output register (one word per cycle unless stalled).
`default_nettype none

module prir_expand import prir_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire stage_t stage,
  output logic        stage_take,
  prir_out_if.source  result
);

  logic [WORD_W-1:0]  rec_word [MAX_WORDS];
  logic [SLOT_W-1:0]  rec_last;
  logic [SLOT_W-1:0]  rec_k;
  logic [POS_W-1:0]   rec_pos;
  logic [CAUSE_W-1:0] rec_cause;
  logic               rec_valid;

  kind_t              kind;
  logic [20:0]        imm21;
  logic [ADDR_W-1:0]  add_a;
  logic [ADDR_W-1:0]  add_b;
  logic [ADDR_W-1:0]  target;
  logic [WORD_W-1:0]  new_word [MAX_WORDS];
  logic [SLOT_W-1:0]  new_last;
  logic               out_load;
  logic               emit;
  logic               rec_end;

  // Absolute target: page-aligned PC for ADRP, plain PC otherwise, plus the offset.
  always_comb begin
    kind  = decode_kind(stage.word);
    imm21 = {stage.word[23:5], stage.word[30:29]};
    case (kind)
      KIND_ADRP: begin
        add_a = {stage.pc[ADDR_W-1:12], 12'h000};
        add_b = {{31{imm21[20]}}, imm21, 12'h000};
      end
      KIND_ADR: begin
        add_a = stage.pc;
        add_b = {{43{imm21[20]}}, imm21};
      end
      default: begin
        add_a = stage.pc;
        add_b = {{36{stage.word[25]}}, stage.word[25:0], 2'b00};
      end
    endcase
    target = add_a + add_b;
  end

  // Build the replacement word sequence for the instruction.
  always_comb begin
    new_word[0] = stage.word;
    new_word[1] = target[31:0];
    new_word[2] = target[31:0];
    new_word[3] = target[63:32];
    new_word[4] = target[63:32];
    case (kind)
      KIND_ADRP, KIND_ADR: begin
        new_word[0] = ldr_literal(stage.word[4:0], LDR_SKIP8);
        new_word[1] = SKIP_B12;
      end
      KIND_B: begin
        new_word[0] = ldr_literal(REG_X16, LDR_SKIP8);
        new_word[1] = BR_X16;
      end
      KIND_BL: begin
        new_word[0] = ldr_literal(REG_X16, LDR_SKIP12);
        new_word[1] = BLR_X16;
        new_word[2] = SKIP_B12;
        new_word[3] = target[31:0];
      end
      default: begin
        new_word[0] = stage.word;
      end
    endcase
    new_last = word_count(kind) - SLOT_W'(1);
  end

  // The record frees up on the cycle its last word moves to the output register.
  assign out_load   = !result.valid || result.ready;
  assign emit       = rec_valid && out_load;
  assign rec_end    = emit && (rec_k == rec_last);
  assign stage_take = !rec_valid || rec_end;

  // Record of the words still to be sent for one instruction.
  always_ff @(posedge clk) begin
    if (stage_take) begin
      for (int i = 0; i < MAX_WORDS; i++) begin
        rec_word[i] <= new_word[i];
      end
      rec_last  <= new_last;
      rec_pos   <= stage.pos;
      rec_cause <= stage.cause;
    end else if (emit) begin
      rec_pos <= rec_pos + POS_W'(1);
    end
    if (rst) begin
      rec_valid <= 1'b0;
      rec_k     <= '0;
    end else if (stage_take) begin
      rec_valid <= stage.valid;
      rec_k     <= '0;
    end else if (emit) begin
      rec_k <= rec_k + SLOT_W'(1);
    end
  end

  // Output register, loaded with one word per transfer.
  always_ff @(posedge clk) begin
    if (out_load) begin
      result.out_word     <= rec_word[rec_k];
      result.out_position <= rec_pos;
      result.first_of_run <= (rec_k == '0);
      result.last_of_run  <= (rec_k == rec_last);
      result.end_cause    <= (rec_k == rec_last) ? rec_cause : CAUSE_NONE;
    end
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= rec_valid;
    end
  end

endmodule

`default_nettype wire
